FILE: sv/track_nearest_harmonic_radius_top_macros.svh
// Assertion helpers for the asserting files (the top-level module includes them).
`ifndef TRACK_NEAREST_HARMONIC_RADIUS_TOP_MACROS_SVH
`define TRACK_NEAREST_HARMONIC_RADIUS_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define THNR_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define THNR_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle check failed");

`endif

FILE: sv/thnr_pkg.sv
package thnr_pkg;

    // Point store geometry.
    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int COUNT_W    = $clog2(MAX_POINTS + 1);
    localparam int ENTRY_W    = 49;

    // Field widths.
    localparam int COORD_W  = 24;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int DD_W     = SQ_W + 1;
    localparam int MIN_W    = 40;
    localparam int ROOT_W   = MIN_W / 2;
    localparam int SQREM_W  = ROOT_W + 2;
    localparam int RADIUS_W = 24;

    // Shared divider widths.
    localparam int DIVD_W = 51;
    localparam int DIVS_W = 51;
    localparam int DIVC_W = $clog2(DIVD_W + 1);

    // Arithmetic constants.
    localparam logic [MIN_W-1:0]    NEAR_CAP   = 40'd655360000000;
    localparam logic [DIVD_W-1:0]   RECIP_ONE  = DIVD_W'(1) << 40;
    localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } thnr_cmd_t;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [COORD_W-1:0] coord_w;
        logic signed [COORD_W-1:0] coord_t;
        logic                      end_of_track;
    } thnr_req_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic                no_tracks;
        logic                exact_hit;
        logic                store_overflow;
    } thnr_rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
    } thnr_div_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_ABS,
        S_SQUARE,
        S_MIN,
        S_SQRT,
        S_RECIP,
        S_FINAL,
        S_FINAL_DIV,
        S_DONE
    } thnr_state_t;

endpackage

FILE: sv/thnr_if.sv
// Request channel: one command item per transfer.
interface thnr_req_if import thnr_pkg::*; ();
    logic      valid;
    logic      ready;
    thnr_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Response channel: one result item per transfer.
interface thnr_rsp_if import thnr_pkg::*; ();
    logic      valid;
    logic      ready;
    thnr_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/thnr_divider.sv
// Restoring divider, one quotient bit per cycle.
module thnr_divider import thnr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output thnr_div_status_t  status,
    output logic [DIVD_W-1:0] quotient
);

    logic [DIVC_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [DIVS_W:0]   trial;

    // One shift-subtract step per cycle while busy.
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[DIVD_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIVC_W'(DIVD_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIVC_W'(1);
            if (cnt_reg == DIVC_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

FILE: sv/track_nearest_harmonic_radius_top.sv
// Channel | Dir | Payload
// req     | in  | command, coord_w, coord_t, end_of_track
// rsp     | out | radius, no_tracks, exact_hit, store_overflow
//
// Clear and add are taken in S_IDLE; points go into a single-port store.
// A query scans each stored point in turn (read, difference, square,
// minimum); each track without an exact hit adds a square root and a
// reciprocal division. A query with no exact hit and a nonzero sum ends
// with a final division; then the output register is loaded.
// rst_n clears the point count and overflow flag; the store needs no pass.
// A finished result waits in the output register; loads are taken meanwhile.
module track_nearest_harmonic_radius_top import thnr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    thnr_req_if.sink   req,
    thnr_rsp_if.source rsp
);

`include "track_nearest_harmonic_radius_top_macros.svh"

    thnr_state_t state_reg, state_next;

    logic [COUNT_W-1:0]        count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic [ADDR_W-1:0]         idx_reg, idx_next;
    logic signed [COORD_W-1:0] qw_reg, qw_next;
    logic signed [COORD_W-1:0] qt_reg, qt_next;
    logic [DIFF_W-1:0]         adw_reg, adw_next;
    logic [DIFF_W-1:0]         adt_reg, adt_next;
    logic                      last_reg, last_next;
    logic [SQ_W-1:0]           sqw_reg, sqw_next;
    logic [SQ_W-1:0]           sqt_reg, sqt_next;
    logic [MIN_W-1:0]          mn_reg, mn_next;
    logic [DIVD_W-1:0]         sum_reg, sum_next;
    logic                      hit_reg, hit_next;
    logic                      none_reg, none_next;
    logic [MIN_W-1:0]          sqv_reg, sqv_next;
    logic [SQREM_W-1:0]        sqr_reg, sqr_next;
    logic [ROOT_W-1:0]         root_reg, root_next;
    logic [4:0]                sqc_reg, sqc_next;
    logic [RADIUS_W-1:0]       radius_reg, radius_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    thnr_rsp_t                 rsp_data_reg, rsp_data_next;

    // Point store and its registered read port.
    logic [ENTRY_W-1:0] mem [MAX_POINTS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_en;
    logic               wr_en;

    logic               xfer_in;
    logic               idx_is_last;
    logic signed [DIFF_W-1:0] dw;
    logic signed [DIFF_W-1:0] dt;
    logic [DD_W-1:0]    dd;
    logic [MIN_W-1:0]   mn_upd;
    logic [SQREM_W+1:0] sq_shift;
    logic [SQREM_W+1:0] sq_trial;

    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic [DIVD_W-1:0] div_quo;
    thnr_div_status_t  div_stat;

    thnr_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_stat),
        .quotient (div_quo)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign xfer_in   = req.valid && req.ready;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    assign idx_is_last = ((COUNT_W'(idx_reg) + COUNT_W'(1)) == count_reg);

    // Datapath helpers for the scan and the square root step.
    assign dw = DIFF_W'($signed(rd_data_reg[48:25])) - DIFF_W'(qw_reg);
    assign dt = DIFF_W'($signed(rd_data_reg[24:1])) - DIFF_W'(qt_reg);
    assign dd = DD_W'(sqw_reg) + DD_W'(sqt_reg);
    assign mn_upd = (dd < DD_W'(mn_reg)) ? dd[MIN_W-1:0] : mn_reg;
    assign sq_shift = {sqr_reg, sqv_reg[MIN_W-1:MIN_W-2]};
    assign sq_trial = (SQREM_W+2)'({root_reg, 2'b01});

    // Sequencer: next state, datapath updates and store access.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        qw_next        = qw_reg;
        qt_next        = qt_reg;
        adw_next       = adw_reg;
        adt_next       = adt_reg;
        last_next      = last_reg;
        sqw_next       = sqw_reg;
        sqt_next       = sqt_reg;
        mn_next        = mn_reg;
        sum_next       = sum_reg;
        hit_next       = hit_reg;
        none_next      = none_reg;
        sqv_next       = sqv_reg;
        sqr_next       = sqr_reg;
        root_next      = root_reg;
        sqc_next       = sqc_reg;
        radius_next    = radius_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        div_start      = 1'b0;
        div_dividend   = RECIP_ONE;
        div_divisor    = DIVS_W'(root_reg);

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (xfer_in)
                begin
                    unique case (req.data.command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        CMD_ADD:
                        begin
                            if (count_reg == COUNT_W'(MAX_POINTS))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        CMD_QUERY:
                        begin
                            qw_next   = req.data.coord_w;
                            qt_next   = req.data.coord_t;
                            idx_next  = '0;
                            mn_next   = NEAR_CAP;
                            sum_next  = '0;
                            hit_next  = 1'b0;
                            none_next = (count_reg == '0);
                            if (count_reg == '0)
                            begin
                                radius_next = RADIUS_MAX;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                adw_next   = dw[DIFF_W-1] ? DIFF_W'(-dw) : DIFF_W'(dw);
                adt_next   = dt[DIFF_W-1] ? DIFF_W'(-dt) : DIFF_W'(dt);
                last_next  = rd_data_reg[0] || idx_is_last;
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                sqw_next   = adw_reg * adw_reg;
                sqt_next   = adt_reg * adt_reg;
                state_next = S_MIN;
            end
            S_MIN:
            begin
                if (!last_reg)
                begin
                    mn_next    = mn_upd;
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = S_READ;
                end
                else if (mn_upd == '0)
                begin
                    hit_next = 1'b1;
                    mn_next  = NEAR_CAP;
                    if (idx_is_last)
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_READ;
                    end
                end
                else
                begin
                    mn_next    = NEAR_CAP;
                    sqv_next   = mn_upd;
                    sqr_next   = '0;
                    root_next  = '0;
                    sqc_next   = 5'(ROOT_W);
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                // Two radicand bits per cycle.
                if (sq_shift >= sq_trial)
                begin
                    sqr_next  = SQREM_W'(sq_shift - sq_trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sqr_next  = SQREM_W'(sq_shift);
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                sqv_next = {sqv_reg[MIN_W-3:0], 2'b00};
                sqc_next = sqc_reg - 5'd1;
                if (sqc_reg == 5'd1)
                begin
                    state_next = S_RECIP;
                    div_start  = 1'b1;
                    div_divisor = DIVS_W'(root_next);
                end
            end
            S_RECIP:
            begin
                if (div_stat.done)
                begin
                    sum_next = sum_reg + div_quo;
                    if (idx_is_last)
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_FINAL:
            begin
                if (hit_reg)
                begin
                    radius_next = '0;
                    state_next  = S_DONE;
                end
                else if (sum_reg == '0)
                begin
                    radius_next = RADIUS_MAX;
                    state_next  = S_DONE;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = RECIP_ONE + (sum_reg >> 1);
                    div_divisor  = DIVS_W'(sum_reg);
                    state_next   = S_FINAL_DIV;
                end
            end
            S_FINAL_DIV:
            begin
                if (div_stat.done)
                begin
                    radius_next = (div_quo > DIVD_W'(RADIUS_MAX)) ? RADIUS_MAX
                                                                  : div_quo[RADIUS_W-1:0];
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hand over once the output register is free.
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next               = 1'b1;
                    rsp_data_next.radius         = radius_reg;
                    rsp_data_next.no_tracks      = none_reg;
                    rsp_data_next.exact_hit      = !none_reg && hit_reg;
                    rsp_data_next.store_overflow = ovf_reg;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        qw_reg       <= qw_next;
        qt_reg       <= qt_next;
        adw_reg      <= adw_next;
        adt_reg      <= adt_next;
        last_reg     <= last_next;
        sqw_reg      <= sqw_next;
        sqt_reg      <= sqt_next;
        mn_reg       <= mn_next;
        sum_reg      <= sum_next;
        hit_reg      <= hit_next;
        none_reg     <= none_next;
        sqv_reg      <= sqv_next;
        sqr_reg      <= sqr_next;
        root_reg     <= root_next;
        sqc_reg      <= sqc_next;
        radius_reg   <= radius_next;
        rsp_data_reg <= rsp_data_next;
    end

    // Store write on add, registered read during a scan. Adds and scans never
    // overlap, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[ADDR_W-1:0]] <= {req.data.coord_w, req.data.coord_t,
                                           req.data.end_of_track};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Checks on the sequencer and the shared divider.
    `THNR_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= COUNT_W'(MAX_POINTS))
    `THNR_ASSERT_IMP(a_flags_excl, clk, rst_n, rsp_valid_reg, !(rsp_data_reg.no_tracks && rsp_data_reg.exact_hit))
    `THNR_ASSERT_IMP(a_div_free, clk, rst_n, div_start, !div_stat.busy)
    `THNR_ASSERT_NEXT(a_empty_query, clk, rst_n, xfer_in && (req.data.command == CMD_QUERY) && (count_reg == '0), state_reg == S_DONE)

endmodule
